[sv/hse_pkg.sv]
// Shared constants and types for the streaming Hamming encoder.
package hse_pkg;

   // Width of one message byte and one code byte.
   localparam int BYTE_W = 8;

   // Width of the valid-bit count that comes with each message byte.
   localparam int BITS_VALID_W = 4;

   // Width of the parity count register.
   localparam int PARITY_W = 3;

   // Smallest usable parity count, reset value, and the Hamming(7,4) setting.
   localparam logic [PARITY_W-1:0] PARITY_MIN = 3'd2;
   localparam logic [PARITY_W-1:0] PARITY_RESET = 3'd3;
   localparam logic [PARITY_W-1:0] PARITY_SEVEN_FOUR = 3'd3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [BITS_VALID_W-1:0] bits_valid_type;
   typedef logic [PARITY_W-1:0] parity_type;

endpackage

[sv/hse_req_if.sv]
// Message byte channel: valid/ready handshake with the source byte payload.
interface hse_req_if;
   import hse_pkg::*;

   logic valid;
   logic ready;
   byte_type data_byte;
   bits_valid_type bits_valid;
   logic end_of_message;

   modport source (output valid, output data_byte, output bits_valid,
      output end_of_message, input ready);
   modport sink (input valid, input data_byte, input bits_valid,
      input end_of_message, output ready);

endinterface

[sv/hse_rsp_if.sv]
// Code byte channel: valid/ready handshake with the packed code byte payload.
interface hse_rsp_if;
   import hse_pkg::*;

   logic valid;
   logic ready;
   byte_type code_byte;
   logic last_of_message;

   modport source (output valid, output code_byte, output last_of_message,
      input ready);
   modport sink (input valid, input code_byte, input last_of_message,
      output ready);

endinterface

[sv/hse_encoder.sv]
// Input register, data bit gathering and codeword generation into a block register.
module hse_encoder #(
   parameter int MAX_PARITY_BITS = 6,
   localparam int NMAX = (1 << MAX_PARITY_BITS) - 1,
   localparam int KMAX = NMAX - MAX_PARITY_BITS,
   localparam int BLK_W = (NMAX > 3 * hse_pkg::BYTE_W) ? NMAX : 3 * hse_pkg::BYTE_W,
   localparam int LEN_W = $clog2(BLK_W + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  hse_pkg::parity_type parity_count,
   hse_req_if.sink req,
   output logic blk_valid,
   input  logic blk_ready,
   output logic [BLK_W-1:0] blk_bits,
   output logic [LEN_W-1:0] blk_len,
   output logic blk_eom
);
   import hse_pkg::*;

   localparam int GC_W = $clog2(KMAX + 1);
   localparam int TOT_W = $clog2(KMAX + BYTE_W);
   localparam int CMB_W = KMAX + BYTE_W;

   // Generic Hamming codeword: data in the non-power-of-two positions, even parity.
   function automatic logic [NMAX-1:0] build_codeword(input logic [KMAX-1:0] d);
      logic [NMAX-1:0] cw;
      logic p;
      int pos;
      int i;
      int di;
      cw = '0;
      di = 0;
      for (pos = 1; pos <= NMAX; pos++) begin
         if ((pos & (pos - 1)) != 0) begin
            cw[pos-1] = d[di];
            di++;
         end
      end
      for (i = 0; i < MAX_PARITY_BITS; i++) begin
         p = 1'b0;
         for (pos = 1; pos <= NMAX; pos++) begin
            if (((pos >> i) & 1) != 0) begin
               p = p ^ cw[pos-1];
            end
         end
         cw[(1 << i) - 1] = p;
      end
      return cw;
   endfunction

   // Hamming(7,4) codeword, position one in bit zero.
   function automatic logic [6:0] encode_seven_four(input logic [3:0] d);
      logic p0;
      logic p1;
      logic p2;
      p0 = d[0] ^ d[1] ^ d[3];
      p1 = d[0] ^ d[2] ^ d[3];
      p2 = d[1] ^ d[2] ^ d[3];
      return {d[3], d[2], d[1], p2, d[0], p1, p0};
   endfunction

   // With two parity bits every data bit becomes its own three-bit codeword.
   function automatic logic [3*BYTE_W-1:0] triple_bits(input logic [BYTE_W-1:0] d);
      logic [3*BYTE_W-1:0] t;
      int j;
      for (j = 0; j < BYTE_W; j++) begin
         t[3*j +: 3] = {3{d[j]}};
      end
      return t;
   endfunction

   logic in_valid_ff;
   byte_type in_byte_ff;
   bits_valid_type in_nb_ff;
   logic in_eom_ff;
   logic [KMAX-1:0] gather_ff;
   logic [KMAX-1:0] gather_in;
   logic [GC_W-1:0] gcnt_ff;
   logic [GC_W-1:0] gcnt_in;
   logic blk_valid_ff;
   logic [BLK_W-1:0] blk_bits_ff;
   logic [LEN_W-1:0] blk_len_ff;
   logic blk_eom_ff;

   logic advance;
   bits_valid_type nb;
   byte_type byte_mask;
   logic [4:0] nb_x3;
   logic [CMB_W-1:0] combined;
   logic [TOT_W-1:0] total;
   logic [TOT_W-1:0] k_val;
   logic [LEN_W-1:0] n_val;
   logic [KMAX-1:0] k_mask;
   logic [BLK_W-1:0] code_bits;
   logic [LEN_W-1:0] code_len;
   logic [KMAX-1:0] left_bits;
   logic [GC_W-1:0] left_cnt;

   // The input register moves on whenever the block register is free.
   assign advance = in_valid_ff && (!blk_valid_ff || blk_ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_nb_ff <= req.bits_valid;
         in_eom_ff <= req.end_of_message;
      end
   end

   // Append the valid message bits behind the gathered ones.
   always_comb begin
      nb = (in_nb_ff > BITS_VALID_W'(BYTE_W)) ? BITS_VALID_W'(BYTE_W) : in_nb_ff;
      byte_mask = ~({BYTE_W{1'b1}} << nb);
      nb_x3 = {nb, 1'b0} + {1'b0, nb};
      combined = CMB_W'(gather_ff) | (CMB_W'(in_byte_ff & byte_mask) << gcnt_ff);
      total = TOT_W'(gcnt_ff) + TOT_W'(nb);
      k_val = TOT_W'((32'd1 << parity_count) - 32'(parity_count) - 32'd1);
      n_val = LEN_W'((32'd1 << parity_count) - 32'd1);
      k_mask = ~({KMAX{1'b1}} << k_val);
   end

   // Turn every completed data group into code bits, first codeword lowest.
   always_comb begin
      code_bits = '0;
      code_len = '0;
      left_bits = KMAX'(combined);
      left_cnt = GC_W'(total);
      case (parity_count)
         PARITY_MIN: begin
            code_bits = BLK_W'(triple_bits(combined[BYTE_W-1:0]));
            code_len = LEN_W'(nb_x3);
            left_bits = '0;
            left_cnt = '0;
         end
         PARITY_SEVEN_FOUR: begin
            if (total >= TOT_W'(8)) begin
               code_bits = BLK_W'({encode_seven_four(combined[7:4]),
                  encode_seven_four(combined[3:0])});
               code_len = LEN_W'(14);
               left_bits = KMAX'(combined >> 8);
               left_cnt = GC_W'(total - TOT_W'(8));
            end else if (total >= TOT_W'(4)) begin
               code_bits = BLK_W'(encode_seven_four(combined[3:0]));
               code_len = LEN_W'(7);
               left_bits = KMAX'(combined >> 4);
               left_cnt = GC_W'(total - TOT_W'(4));
            end
         end
         default: begin
            if (total >= k_val) begin
               code_bits = BLK_W'(build_codeword(KMAX'(combined) & k_mask));
               code_len = n_val;
               left_bits = KMAX'(combined >> k_val);
               left_cnt = GC_W'(total - k_val);
            end
         end
      endcase
   end

   // The end of a message drops the leftover data bits.
   always_comb begin
      gather_in = gather_ff;
      gcnt_in = gcnt_ff;
      if (advance) begin
         gather_in = in_eom_ff ? '0 : left_bits;
         gcnt_in = in_eom_ff ? '0 : left_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         gather_ff <= '0;
         gcnt_ff <= '0;
      end else begin
         gather_ff <= gather_in;
         gcnt_ff <= gcnt_in;
      end
   end

   // Block register toward the packer.
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
      end else if (advance) begin
         blk_valid_ff <= 1'b1;
      end else if (blk_ready) begin
         blk_valid_ff <= 1'b0;
      end
      if (advance) begin
         blk_bits_ff <= code_bits;
         blk_len_ff <= code_len;
         blk_eom_ff <= in_eom_ff;
      end
   end

   assign blk_valid = blk_valid_ff;
   assign blk_bits = blk_bits_ff;
   assign blk_len = blk_len_ff;
   assign blk_eom = blk_eom_ff;

endmodule

[sv/hse_packer.sv]
// Code bit buffer that packs blocks of code bits into bytes and drives the output register.
module hse_packer #(
   parameter int MAX_PARITY_BITS = 6,
   localparam int NMAX = (1 << MAX_PARITY_BITS) - 1,
   localparam int BLK_W = (NMAX > 3 * hse_pkg::BYTE_W) ? NMAX : 3 * hse_pkg::BYTE_W,
   localparam int LEN_W = $clog2(BLK_W + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  logic blk_valid,
   output logic blk_ready,
   input  logic [BLK_W-1:0] blk_bits,
   input  logic [LEN_W-1:0] blk_len,
   input  logic blk_eom,
   hse_rsp_if.source rsp
);
   import hse_pkg::*;

   localparam int BUF_W = BLK_W + BYTE_W - 1;
   localparam int CNT_W = $clog2(BUF_W + 1);
   localparam int SH_W = $clog2(BYTE_W);

   logic [BUF_W-1:0] buf_ff;
   logic [BUF_W-1:0] buf_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic eom_ff;
   logic eom_in;
   logic rsp_valid_ff;
   byte_type code_ff;
   logic last_ff;

   logic out_free;
   logic emit;
   logic final_byte;
   logic [BUF_W-1:0] buf_rest;
   logic [CNT_W-1:0] cnt_rest;
   logic eom_rest;
   logic merge;
   logic [CNT_W-1:0] cnt_sum;

   // A byte leaves per cycle while output is free: eight bits, or padded at message end.
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign final_byte = eom_ff && (cnt_ff <= CNT_W'(BYTE_W));
   assign emit = out_free && ((cnt_ff >= CNT_W'(BYTE_W)) || (eom_ff && (cnt_ff != '0)));

   // Buffer state after this cycle's byte is gone.
   always_comb begin
      buf_rest = buf_ff;
      cnt_rest = cnt_ff;
      eom_rest = eom_ff;
      if (emit) begin
         buf_rest = buf_ff >> BYTE_W;
         cnt_rest = final_byte ? '0 : cnt_ff - CNT_W'(BYTE_W);
         eom_rest = final_byte ? 1'b0 : eom_ff;
      end
   end

   // A new block joins once less than a byte is left and no flush is under way.
   assign blk_ready = (cnt_rest < CNT_W'(BYTE_W)) && !eom_rest;
   assign merge = blk_valid && blk_ready;
   assign cnt_sum = cnt_rest + CNT_W'(blk_len);

   always_comb begin
      buf_in = buf_rest;
      cnt_in = cnt_rest;
      eom_in = eom_rest;
      if (merge) begin
         buf_in = buf_rest | (BUF_W'(blk_bits) << cnt_rest[SH_W-1:0]);
         cnt_in = cnt_sum;
         eom_in = blk_eom && (cnt_sum != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         buf_ff <= '0;
         cnt_ff <= '0;
         eom_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         eom_ff <= eom_in;
      end
   end

   // Output register; the buffer keeps filling while a beat waits here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         code_ff <= buf_ff[BYTE_W-1:0];
         last_ff <= final_byte;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.code_byte = code_ff;
   assign rsp.last_of_message = last_ff;

endmodule

[sv/hamming_stream_encoder.sv]
// Streaming Hamming encoder top level: parity count register, encoder and packer.
//
// Message bytes enter on req_bus, one beat per byte, read least significant bit
// first; bits_valid gives the number of valid low bits and end_of_message marks the
// last byte. Code bytes leave on rsp_bus, packed least significant bit first, and
// last_of_message is set on the final byte of a message (a zero padded partial byte
// if bits are left over). Leftover data bits short of a full group are dropped.
// csr_write_en with csr_write_data sets the parity count (2 to MAX_PARITY_BITS,
// clamped) and clears any message in progress; write it only while the block is idle.
// The first code byte of a beat passes the block register, the code bit buffer and
// the output register. Throughput: the packer sends at most one code byte per cycle,
// so with rsp_bus ready an input beat is taken every cycle as long as no beat yields more
// than one code byte; with two parity bits a byte yields three code bytes, so beats wait.
// Reset (synchronous) empties the pipeline and sets the parity count to three.
// When rsp_bus stalls, the output register, the code bit buffer, the block register
// and the input register fill in turn before req_bus.ready drops.
module hamming_stream_encoder #(
   parameter int MAX_PARITY_BITS = 6,
   localparam int NMAX = (1 << MAX_PARITY_BITS) - 1,
   localparam int BLK_W = (NMAX > 3 * hse_pkg::BYTE_W) ? NMAX : 3 * hse_pkg::BYTE_W,
   localparam int LEN_W = $clog2(BLK_W + 1)
) (
   input  logic clock,
   input  logic reset,
   hse_req_if.sink req_bus,
   hse_rsp_if.source rsp_bus,
   input  logic csr_write_en,
   input  hse_pkg::parity_type csr_write_data
);
   import hse_pkg::*;

   parity_type parity_ff;
   parity_type parity_eff;
   logic blk_valid;
   logic blk_ready;
   logic [BLK_W-1:0] blk_bits;
   logic [LEN_W-1:0] blk_len;
   logic blk_eom;

   // Parity count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= PARITY_RESET;
      end else if (csr_write_en) begin
         parity_ff <= csr_write_data;
      end
   end

   // Out-of-range counts act as the nearest legal one.
   always_comb begin
      parity_eff = parity_ff;
      if (parity_ff < PARITY_MIN) begin
         parity_eff = PARITY_MIN;
      end else if (parity_ff > PARITY_W'(MAX_PARITY_BITS)) begin
         parity_eff = PARITY_W'(MAX_PARITY_BITS);
      end
   end

   hse_encoder #(
      .MAX_PARITY_BITS(MAX_PARITY_BITS)
   ) u_encoder (
      .clock(clock),
      .reset(reset),
      .clear(csr_write_en),
      .parity_count(parity_eff),
      .req(req_bus),
      .blk_valid(blk_valid),
      .blk_ready(blk_ready),
      .blk_bits(blk_bits),
      .blk_len(blk_len),
      .blk_eom(blk_eom)
   );

   hse_packer #(
      .MAX_PARITY_BITS(MAX_PARITY_BITS)
   ) u_packer (
      .clock(clock),
      .reset(reset),
      .clear(csr_write_en),
      .blk_valid(blk_valid),
      .blk_ready(blk_ready),
      .blk_bits(blk_bits),
      .blk_len(blk_len),
      .blk_eom(blk_eom),
      .rsp(rsp_bus)
   );

endmodule
